// ===== sv/ccca_pkg.sv =====
// Package for the calendar clock advance block: widths, constants, codes
// and the month length lookup. No dependencies.
`default_nettype none

package ccca_pkg;

    // Field widths
    localparam int ADD_DAYS_W    = 10;
    localparam int ADD_HOURS_W   = 10;
    localparam int ADD_MINUTES_W = 16;
    localparam int MINUTE_W      = 6;
    localparam int HOUR_W        = 5;
    localparam int DAY_W         = 5;
    localparam int MONTH_W       = 4;
    localparam int YEAR_OUT_W    = 16;
    localparam int WEEKDAY_W     = 5;

    // Configuration registers
    localparam int MONTH_LEN_W     = 5;
    localparam int TABLE_ENTRIES   = 12;
    localparam int MONTH_TABLE_W   = MONTH_LEN_W * TABLE_ENTRIES;
    localparam int MONTH_COUNT_W   = 4;
    localparam int WEEK_LEN_W      = 5;
    localparam int CFG_DATA_W      = MONTH_TABLE_W;
    localparam int CFG_IDX_W       = 2;

    localparam logic [MONTH_TABLE_W-1:0] MONTH_TABLE_RST = 60'd1151794505154789279;
    localparam logic [MONTH_COUNT_W-1:0] MONTH_COUNT_RST = 4'd12;
    localparam logic [WEEK_LEN_W-1:0]    WEEK_LEN_RST    = 5'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MONTH_LENGTHS = 2'd0,
        CFG_MONTH_COUNT   = 2'd1,
        CFG_WEEK_LENGTH   = 2'd2
    } cfg_idx_t;

    // Months actually backed by the table
    localparam int MAX_MONTHS = 12;

    localparam int YEAR_BITS_DEF = 16;

    // Time constants
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;

    // Shared compare/subtract unit and divider sequencing
    localparam int UNIT_A_W     = 11;
    localparam int UNIT_B_W     = 6;
    localparam int DIV_W        = 17;
    localparam int DIV_STEPS    = DIV_W;
    localparam int STEP_CNT_W   = $clog2(DIV_STEPS + 1);

    // Reset values of the time state
    localparam logic [MINUTE_W-1:0] MINUTE_RST = 6'd0;
    localparam logic [HOUR_W-1:0]   HOUR_RST   = 5'd12;
    localparam logic [DAY_W-1:0]    DAY_M1_RST = 5'd0;
    localparam logic [MONTH_W-1:0]  MONTH_RST  = 4'd0;

    // Length of month idx; out-of-table months and zero entries read one day.
    function automatic logic [MONTH_LEN_W-1:0] month_len(
        input logic [MONTH_TABLE_W-1:0] tbl,
        input logic [MONTH_W-1:0]       idx
    );
        logic [MONTH_LEN_W-1:0] len;
        len = '0;
        if (int'(idx) < MAX_MONTHS && int'(idx) < TABLE_ENTRIES)
        begin
            len = tbl[idx * MONTH_LEN_W +: MONTH_LEN_W];
        end
        if (len == '0)
        begin
            len = MONTH_LEN_W'(1);
        end
        return len;
    endfunction

    // Months in use, clamped to 1..MAX_MONTHS
    function automatic logic [MONTH_COUNT_W-1:0] eff_month_count(
        input logic [MONTH_COUNT_W-1:0] cnt
    );
        logic [MONTH_COUNT_W-1:0] r;
        r = cnt;
        if (cnt == '0)
        begin
            r = MONTH_COUNT_W'(1);
        end
        else if (int'(cnt) > MAX_MONTHS)
        begin
            r = MONTH_COUNT_W'(MAX_MONTHS);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ccca_if.sv =====
// Valid/ready channel interfaces for input and result beats.
// Depends on ccca_pkg.
`default_nettype none

interface ccca_in_if;
    import ccca_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ADD_DAYS_W-1:0]    add_days;
    logic [ADD_HOURS_W-1:0]   add_hours;
    logic [ADD_MINUTES_W-1:0] add_minutes;

    modport source (output valid, output add_days, output add_hours, output add_minutes,
                    input ready);
    modport sink   (input valid, input add_days, input add_hours, input add_minutes,
                    output ready);
endinterface

interface ccca_out_if;
    import ccca_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MINUTE_W-1:0]   minute_now;
    logic [HOUR_W-1:0]     hour_now;
    logic [DAY_W-1:0]      day_now;
    logic [MONTH_W-1:0]    month_now;
    logic [YEAR_OUT_W-1:0] year_now;
    logic [WEEKDAY_W-1:0]  weekday_now;

    modport source (output valid, output minute_now, output hour_now, output day_now,
                    output month_now, output year_now, output weekday_now,
                    input ready);
    modport sink   (input valid, input minute_now, input hour_now, input day_now,
                    input month_now, input year_now, input weekday_now,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/ccca_cmpsub.sv =====
// Shared compare-and-subtract unit: a >= b and a - b.
// Depends on ccca_pkg.
`default_nettype none

module ccca_cmpsub (
    input  logic [ccca_pkg::UNIT_A_W-1:0] a,
    input  logic [ccca_pkg::UNIT_B_W-1:0] b,
    output logic                          ge,
    output logic [ccca_pkg::UNIT_A_W-1:0] diff
);
    import ccca_pkg::*;

    logic [UNIT_A_W:0] d_ext;

    assign d_ext = {1'b0, a} - {1'b0, UNIT_A_W'(b)};
    assign ge    = ~d_ext[UNIT_A_W];
    assign diff  = d_ext[UNIT_A_W-1:0];

endmodule

`default_nettype wire

// ===== sv/custom_calendar_clock_advance.sv =====
// Top level of the calendar clock advance block: sequencer, time state,
// configuration registers and result register. Depends on ccca_pkg,
// ccca_if and ccca_cmpsub.
`default_nettype none

// Calendar counter. Each input beat adds days, hours and minutes to the
// stored time and yields one result beat with the normalized minute, hour,
// day of month (from one), month index, year and weekday (day-1 mod week).
// The minute sum is split into hours and minutes by a reciprocal multiply,
// then the hour sum into days and hours the same way. One compare/subtract
// unit does the rest under a small sequencer: each month carry is one step,
// then the weekday remainder comes from restoring division. The input is
// not ready while an item is in work. The result sits in an output
// register, so a new beat is taken while it waits, but the next result
// cannot land until that one is taken; a stall on the result side then
// holds the sequencer in its hand-off state. Configuration writes (month
// table, months per year, week length) are taken at any time but are
// meant to come only while the block is idle. No clearing pass after
// reset.

module custom_calendar_clock_advance #(
    parameter int YEAR_BITS = ccca_pkg::YEAR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ccca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccca_pkg::CFG_DATA_W-1:0] cfg_wdata,
    ccca_in_if.sink                         in_ch,
    ccca_out_if.source                      out_ch
);
    import ccca_pkg::*;

    // Reciprocals: n/60 = ((n>>2) * ceil(2^19/15)) >> 19 for n < 2^17,
    // n/24 = ((n>>3) * ceil(2^10/3)) >> 10 for n < 2^12.
    localparam int MIN_RECIP        = 34953;
    localparam int MIN_RECIP_SHIFT  = 19;
    localparam int HOUR_RECIP       = 342;
    localparam int HOUR_RECIP_SHIFT = 10;
    localparam int PROD_W           = 32;

    // Sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIVM  = 8'b0000_0010,  // minutes / 60
        ST_HSUM  = 8'b0000_0100,  // hours + minute carry
        ST_DIVH  = 8'b0000_1000,  // hours / 24
        ST_DSUM  = 8'b0001_0000,  // day-1 + days + hour carry
        ST_MONTH = 8'b0010_0000,  // one month carry per cycle
        ST_WDIV  = 8'b0100_0000,  // (day-1) mod week
        ST_OUT   = 8'b1000_0000   // hand result to output register
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [MONTH_TABLE_W-1:0] month_tbl_reg;
    logic [MONTH_COUNT_W-1:0] month_cnt_reg;
    logic [WEEK_LEN_W-1:0]    week_len_reg;

    // Time state; day is kept as day minus one
    logic [MINUTE_W-1:0]  minute_reg, minute_next;
    logic [HOUR_W-1:0]    hour_reg, hour_next;
    logic [DAY_W-1:0]     day_m1_reg, day_m1_next;
    logic [MONTH_W-1:0]   month_reg, month_next;
    logic [YEAR_BITS-1:0] year_reg, year_next;

    // Work registers
    logic [DIV_W-1:0]      work_reg, work_next;     // sums / quotient / day-1
    logic [UNIT_A_W-1:0]   rem_reg, rem_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ADD_DAYS_W-1:0]  add_days_reg;
    logic [ADD_HOURS_W-1:0] add_hours_reg;

    // Result register
    logic                  out_valid_reg;
    logic [MINUTE_W-1:0]   out_minute_reg;
    logic [HOUR_W-1:0]     out_hour_reg;
    logic [DAY_W-1:0]      out_day_reg;
    logic [MONTH_W-1:0]    out_month_reg;
    logic [YEAR_OUT_W-1:0] out_year_reg;
    logic [WEEKDAY_W-1:0]  out_weekday_reg;

    logic in_fire, out_fire, out_load;

    // Shared unit
    logic [UNIT_A_W-1:0] unit_a, unit_diff;
    logic [UNIT_B_W-1:0] unit_b;
    logic                unit_ge;

    // Constant dividers for minutes and hours
    logic [PROD_W-1:0] min_prod, hour_prod;
    logic [DIV_W-1:0]  min_quot, min_rem, hour_quot, hour_rem;

    logic [MONTH_LEN_W-1:0]   cur_len;
    logic [MONTH_COUNT_W-1:0] cur_count;
    logic [WEEK_LEN_W-1:0]    cur_week;
    logic [MONTH_W-1:0]       month_inc;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready = (state_reg == ST_IDLE);

    assign cur_len   = month_len(month_tbl_reg, month_reg);
    assign cur_count = eff_month_count(month_cnt_reg);
    assign cur_week  = (week_len_reg == '0) ? WEEK_LEN_W'(1) : week_len_reg;
    assign month_inc = month_reg + MONTH_W'(1);

    // Minute sum is at most 59 + 65535, hour sum at most 23 + 1023 + 1093
    assign min_prod  = PROD_W'(work_reg[DIV_W-1:2]) * PROD_W'(MIN_RECIP);
    assign min_quot  = DIV_W'(min_prod >> MIN_RECIP_SHIFT);
    assign min_rem   = work_reg - min_quot * DIV_W'(MIN_PER_HOUR);
    assign hour_prod = PROD_W'(work_reg[DIV_W-1:3]) * PROD_W'(HOUR_RECIP);
    assign hour_quot = DIV_W'(hour_prod >> HOUR_RECIP_SHIFT);
    assign hour_rem  = work_reg - hour_quot * DIV_W'(HOUR_PER_DAY);

    // Month loop compares day-1 against the length directly; division steps
    // shift the next dividend bit into the partial remainder.
    always_comb
    begin
        unit_a = {rem_reg[UNIT_A_W-2:0], work_reg[DIV_W-1]};
        unit_b = UNIT_B_W'(MIN_PER_HOUR);
        unique case (state_reg)
            ST_WDIV:  unit_b = UNIT_B_W'(cur_week);
            ST_MONTH:
            begin
                unit_a = work_reg[UNIT_A_W-1:0];
                unit_b = UNIT_B_W'(cur_len);
            end
            default:  unit_b = UNIT_B_W'(MIN_PER_HOUR);
        endcase
    end

    ccca_cmpsub u_cmpsub (
        .a    (unit_a),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        work_next   = work_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        minute_next = minute_reg;
        hour_next   = hour_reg;
        day_m1_next = day_m1_reg;
        month_next  = month_reg;
        year_next   = year_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    work_next  = DIV_W'(minute_reg) + DIV_W'(in_ch.add_minutes);
                    state_next = ST_DIVM;
                end
            end
            ST_DIVM:
            begin
                minute_next = min_rem[MINUTE_W-1:0];
                work_next   = min_quot;
                state_next  = ST_HSUM;
            end
            ST_HSUM:
            begin
                work_next  = DIV_W'(hour_reg) + DIV_W'(add_hours_reg) + work_reg;
                state_next = ST_DIVH;
            end
            ST_DIVH:
            begin
                hour_next  = hour_rem[HOUR_W-1:0];
                work_next  = hour_quot;
                state_next = ST_DSUM;
            end
            ST_DSUM:
            begin
                work_next  = DIV_W'(day_m1_reg) + DIV_W'(add_days_reg) + work_reg;
                state_next = ST_MONTH;
            end
            ST_MONTH:
            begin
                if (unit_ge)
                begin
                    // day beyond this month: carry one month
                    work_next = DIV_W'(unit_diff);
                    if (MONTH_COUNT_W'(month_inc) >= cur_count)
                    begin
                        month_next = '0;
                        year_next  = year_reg + YEAR_BITS'(1);
                    end
                    else
                    begin
                        month_next = month_inc;
                    end
                end
                else
                begin
                    day_m1_next = work_reg[DAY_W-1:0];
                    rem_next    = '0;
                    cnt_next    = STEP_CNT_W'(DIV_STEPS);
                    state_next  = ST_WDIV;
                end
            end
            ST_WDIV:
            begin
                rem_next  = unit_ge ? unit_diff : unit_a;
                work_next = {work_reg[DIV_W-2:0], unit_ge};
                cnt_next  = cnt_reg - STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            minute_reg    <= MINUTE_RST;
            hour_reg      <= HOUR_RST;
            day_m1_reg    <= DAY_M1_RST;
            month_reg     <= MONTH_RST;
            year_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            month_tbl_reg <= MONTH_TABLE_RST;
            month_cnt_reg <= MONTH_COUNT_RST;
            week_len_reg  <= WEEK_LEN_RST;
        end
        else
        begin
            state_reg  <= state_next;
            minute_reg <= minute_next;
            hour_reg   <= hour_next;
            day_m1_reg <= day_m1_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            cnt_reg    <= cnt_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MONTH_LENGTHS: month_tbl_reg <= cfg_wdata[MONTH_TABLE_W-1:0];
                    CFG_MONTH_COUNT:   month_cnt_reg <= cfg_wdata[MONTH_COUNT_W-1:0];
                    CFG_WEEK_LENGTH:   week_len_reg  <= cfg_wdata[WEEK_LEN_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (in_fire)
        begin
            add_days_reg  <= in_ch.add_days;
            add_hours_reg <= in_ch.add_hours;
        end
        if (out_load)
        begin
            out_minute_reg  <= minute_reg;
            out_hour_reg    <= hour_reg;
            out_day_reg     <= day_m1_reg + DAY_W'(1);
            out_month_reg   <= month_reg;
            out_year_reg    <= YEAR_OUT_W'(year_reg);
            out_weekday_reg <= rem_reg[WEEKDAY_W-1:0];
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.minute_now  = out_minute_reg;
    assign out_ch.hour_now    = out_hour_reg;
    assign out_ch.day_now     = out_day_reg;
    assign out_ch.month_now   = out_month_reg;
    assign out_ch.year_now    = out_year_reg;
    assign out_ch.weekday_now = out_weekday_reg;

endmodule

`default_nettype wire

// ===== tb/tb_custom_calendar_clock_advance.sv =====
// Self-checking testbench for custom_calendar_clock_advance: a directed table
// followed by randomized phases, each result compared with a calendar predictor
// or a hand-written reading. Depends on ccca_pkg, ccca_if and the block itself.
`default_nettype none

module tb_custom_calendar_clock_advance;
    timeunit 1ns;
    timeprecision 1ps;

    import ccca_pkg::*;

    // Run shape. Worst item: ~1150 month carries with one-day months, plus gaps.
    localparam int          RANDOM_PHASES   = 10;
    localparam int          BEATS_PER_PHASE = 125;
    localparam int          HEAVY_PHASE     = 2;
    localparam int          STEADY_PHASE    = 3;
    localparam int unsigned CYCLE_LIMIT     = 8_000_000;
    localparam int          DRAIN_CYCLES    = 80;
    localparam int          MAX_PRINTS      = 100;

    // One advance request: what the sender puts on the input channel
    typedef struct packed {
        logic [ADD_DAYS_W-1:0]    days;
        logic [ADD_HOURS_W-1:0]   hours;
        logic [ADD_MINUTES_W-1:0] minutes;
    } advance_t;

    // One calendar reading: field order matches the result channel
    typedef struct packed {
        logic [MINUTE_W-1:0]   minute;
        logic [HOUR_W-1:0]     hour;
        logic [DAY_W-1:0]      day;
        logic [MONTH_W-1:0]    month;
        logic [YEAR_OUT_W-1:0] year;
        logic [WEEKDAY_W-1:0]  weekday;
    } stamp_t;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } row_kind_t;

    // Directed table row: either a register write or an advance beat.
    // 'typed' rows carry a hand-written expected reading.
    typedef struct packed {
        row_kind_t             kind;
        cfg_idx_t              sel;
        logic [CFG_DATA_W-1:0] value;
        advance_t              step;
        logic                  typed;
        stamp_t                want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ccca_in_if  in_ch ();
    ccca_out_if out_ch ();

    custom_calendar_clock_advance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the calendar registers and the time state
    logic [MONTH_TABLE_W-1:0] cal_table  = MONTH_TABLE_RST;
    logic [MONTH_COUNT_W-1:0] cal_count  = MONTH_COUNT_RST;
    logic [WEEK_LEN_W-1:0]    cal_week   = WEEK_LEN_RST;
    logic [MINUTE_W-1:0]      cal_minute = 6'd0;
    logic [HOUR_W-1:0]        cal_hour   = 5'd12;
    logic [DAY_W-1:0]         cal_day    = 5'd1;
    logic [MONTH_W-1:0]       cal_month  = 4'd0;
    logic [YEAR_OUT_W-1:0]    cal_year   = 16'd0;

    stamp_t      pending_stamps[$];   // readings owed by the block, oldest first
    plan_row_t   plan[$];
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    bit          no_idle     = 1'b0;  // set for one whole phase: no gaps on either side

    task automatic report_mismatch(input string msg);
        fault_count++;
        if (fault_count <= MAX_PRINTS)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    // Day count of a month; months past the table and zero entries read one day
    function automatic int unsigned days_in_month(input logic [MONTH_W-1:0] idx);
        int unsigned n;
        n = 0;
        if (int'(idx) < MAX_MONTHS)
        begin
            n = 32'(cal_table[idx * MONTH_LEN_W +: MONTH_LEN_W]);
        end
        return (n == 0) ? 1 : n;
    endfunction

    // Add the request to the stored time, normalize, return the new reading
    function automatic stamp_t advance_calendar(input advance_t a);
        int unsigned mins;
        int unsigned hrs;
        int unsigned dys;
        int unsigned span;
        int unsigned months_used;
        int unsigned wk;
        stamp_t      s;
        // out-of-range month count clamps to 1..MAX_MONTHS, zero week acts as one
        months_used = (cal_count == '0) ? 1 : 32'(cal_count);
        if (months_used > MAX_MONTHS)
        begin
            months_used = MAX_MONTHS;
        end
        wk = (cal_week == '0) ? 1 : 32'(cal_week);

        mins = 32'(cal_minute) + 32'(a.minutes);
        hrs  = 32'(cal_hour) + 32'(a.hours) + mins / MIN_PER_HOUR;
        mins = mins % MIN_PER_HOUR;
        dys  = 32'(cal_day) + 32'(a.days) + hrs / HOUR_PER_DAY;
        hrs  = hrs % HOUR_PER_DAY;

        // a month index left above a lowered month count only wraps on a carry
        span = days_in_month(cal_month);
        while (dys > span)
        begin
            dys -= span;
            cal_month = cal_month + 1'b1;
            if (32'(cal_month) >= months_used)
            begin
                cal_month = '0;
                cal_year  = cal_year + 1'b1;
            end
            span = days_in_month(cal_month);
        end

        cal_minute = MINUTE_W'(mins);
        cal_hour   = HOUR_W'(hrs);
        cal_day    = DAY_W'(dys);

        s.minute  = cal_minute;
        s.hour    = cal_hour;
        s.day     = cal_day;
        s.month   = cal_month;
        s.year    = cal_year;
        s.weekday = WEEKDAY_W'((dys - 1) % wk);
        return s;
    endfunction

    // Table row builders
    function automatic plan_row_t beat(input int d, input int h, input int m);
        plan_row_t r;
        r              = '0;
        r.kind         = ROW_BEAT;
        r.step.days    = ADD_DAYS_W'(d);
        r.step.hours   = ADD_HOURS_W'(h);
        r.step.minutes = ADD_MINUTES_W'(m);
        return r;
    endfunction

    function automatic plan_row_t beat_is(input int d, input int h, input int m,
                                          input int mi, input int hr, input int dy,
                                          input int mo, input int yr, input int wd);
        plan_row_t r;
        r         = beat(d, h, m);
        r.typed   = 1'b1;
        r.want    = {MINUTE_W'(mi), HOUR_W'(hr), DAY_W'(dy), MONTH_W'(mo),
                     YEAR_OUT_W'(yr), WEEKDAY_W'(wd)};
        return r;
    endfunction

    function automatic plan_row_t setting(input cfg_idx_t sel,
                                          input logic [CFG_DATA_W-1:0] v);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.sel   = sel;
        r.value = v;
        return r;
    endfunction

    // Random advance. Heavy mode is mostly maximal requests so the year wraps.
    function automatic advance_t random_advance(input bit heavy);
        advance_t    a;
        int unsigned r;
        a = '0;
        r = $urandom_range(0, 99);
        if (heavy && r < 85)
        begin
            a = '1;
        end
        else if (heavy || (r >= 80 && r < 95))
        begin
            a.days    = ADD_DAYS_W'($urandom);
            a.hours   = ADD_HOURS_W'($urandom);
            a.minutes = ADD_MINUTES_W'($urandom);
        end
        else if (r < 35)
        begin
            a.minutes = 16'd1;      // plain tick
        end
        else if (r < 60)
        begin
            a.days    = ADD_DAYS_W'($urandom_range(0, 2));
            a.hours   = ADD_HOURS_W'($urandom_range(0, 5));
            a.minutes = ADD_MINUTES_W'($urandom_range(0, 120));
        end
        else if (r < 80)
        begin
            a.days    = ADD_DAYS_W'($urandom_range(0, 40));
            a.hours   = ADD_HOURS_W'($urandom_range(0, 48));
            a.minutes = ADD_MINUTES_W'($urandom_range(0, 3000));
        end
        else
        begin
            a.days    = $urandom_range(0, 1) ? '1 : '0;
            a.hours   = $urandom_range(0, 1) ? '1 : '0;
            a.minutes = $urandom_range(0, 1) ? '1 : '0;
        end
        return a;
    endfunction

    // Register write: only once the block has handed back everything owed.
    // cfg_we stays high across back-to-back writes; the next beat drops it.
    task automatic write_setting(input cfg_idx_t sel, input logic [CFG_DATA_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (pending_stamps.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= v;
        @(posedge clk);
        case (sel)
            CFG_MONTH_LENGTHS: cal_table = v[MONTH_TABLE_W-1:0];
            CFG_MONTH_COUNT:   cal_count = v[MONTH_COUNT_W-1:0];
            CFG_WEEK_LENGTH:   cal_week  = v[WEEK_LEN_W-1:0];
            default:           ;
        endcase
    endtask

    // Offer one beat, wait for the handshake, then book the expected reading
    task automatic run_advance(input advance_t a, input logic typed, input stamp_t want);
        int     gap;
        stamp_t s;
        gap    = 0;
        cfg_we <= 1'b0;
        if (!no_idle && $urandom_range(0, 99) < 15)
        begin
            gap = $urandom_range(1, 60);
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.add_days    <= a.days;
        in_ch.add_hours   <= a.hours;
        in_ch.add_minutes <= a.minutes;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        s = advance_calendar(a);
        pending_stamps.push_back(typed ? want : s);
    endtask

    // Result side: random back-pressure, compare every accepted beat with the
    // oldest booked reading.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        stamp_t got;
        stamp_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.minute_now, out_ch.hour_now, out_ch.day_now,
                       out_ch.month_now, out_ch.year_now, out_ch.weekday_now};
                if (pending_stamps.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    want = pending_stamps.pop_front();
                    if (got.minute !== want.minute)
                        report_mismatch($sformatf("minute_now got %0d want %0d",
                                                  got.minute, want.minute));
                    if (got.hour !== want.hour)
                        report_mismatch($sformatf("hour_now got %0d want %0d",
                                                  got.hour, want.hour));
                    if (got.day !== want.day)
                        report_mismatch($sformatf("day_now got %0d want %0d",
                                                  got.day, want.day));
                    if (got.month !== want.month)
                        report_mismatch($sformatf("month_now got %0d want %0d",
                                                  got.month, want.month));
                    if (got.year !== want.year)
                        report_mismatch($sformatf("year_now got %0d want %0d",
                                                  got.year, want.year));
                    if (got.weekday !== want.weekday)
                        report_mismatch($sformatf("weekday_now got %0d want %0d",
                                                  got.weekday, want.weekday));
                end
            end
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 8);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        plan_row_t             row;
        logic [CFG_DATA_W-1:0] tbl;
        int unsigned           cnt;
        int unsigned           wk;
        int unsigned           pick;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_MONTH_LENGTHS;
        cfg_wdata         <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.add_days    <= '0;
        in_ch.add_hours   <= '0;
        in_ch.add_minutes <= '0;

        // Directed part. Reset time is 12:00, day 1, month 0, year 0.
        plan = '{
            beat_is(0, 0, 1,       1, 12, 1, 0, 0, 0),   // plain tick from reset
            beat_is(0, 0, 59,      0, 13, 1, 0, 0, 0),   // minute carry
            beat_is(0, 11, 0,      0, 0, 2, 0, 0, 1),    // hour carry into day 2
            beat_is(0, 0, 0,       0, 0, 2, 0, 0, 1),    // empty advance
            beat_is(29, 0, 0,      0, 0, 31, 0, 0, 2),   // last day of a 31-day month
            beat_is(1, 0, 0,       0, 0, 1, 1, 0, 0),    // month carry
            beat(0, 0, 65535),
            beat(0, 1023, 0),
            beat(1023, 0, 0),
            beat(1023, 1023, 65535),
            setting(CFG_WEEK_LENGTH, 0),                 // zero week acts as one
            beat(0, 0, 1),
            setting(CFG_WEEK_LENGTH, 31),
            beat(30, 0, 0),
            setting(CFG_MONTH_LENGTHS, 0),               // every month one day long
            beat(5, 0, 0),
            setting(CFG_MONTH_LENGTHS, '1),
            setting(CFG_MONTH_COUNT, 15),                // above range, acts as twelve
            beat(400, 0, 0),
            setting(CFG_MONTH_COUNT, 0),                 // zero acts as one
            beat(0, 0, 1),                               // month left above the count
            beat(40, 0, 0),
            setting(CFG_MONTH_LENGTHS, MONTH_TABLE_RST),
            setting(CFG_MONTH_COUNT, 12),
            setting(CFG_WEEK_LENGTH, 7),
            beat(300, 0, 0),                             // well into the year
            setting(CFG_MONTH_COUNT, 3),                 // lowered under the month index
            beat(0, 0, 1),
            beat(31, 0, 0),                              // carry wraps to month 0
            setting(CFG_MONTH_COUNT, 12)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_CFG)
                write_setting(row.sel, row.value);
            else
                run_advance(row.step, row.typed, row.want);
        end

        // Random phases, each under its own calendar setup
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0, STEADY_PHASE:
                begin
                    tbl = MONTH_TABLE_RST;
                    cnt = 12;
                    wk  = 7;
                end
                1:
                begin
                    tbl = '1;
                    cnt = 15;
                    wk  = 31;
                end
                HEAVY_PHASE:
                begin
                    // one-day months, one month per year: big steps wrap the year
                    tbl = '0;
                    cnt = 0;
                    wk  = 0;
                end
                default:
                begin
                    pick = $urandom_range(0, 2);
                    tbl  = CFG_DATA_W'({$urandom, $urandom});
                    if (pick != 2)
                    begin
                        for (int k = 0; k < TABLE_ENTRIES; k++)
                        begin
                            tbl[k * MONTH_LEN_W +: MONTH_LEN_W] =
                                (pick == 0) ? MONTH_LEN_W'($urandom_range(28, 31))
                                            : MONTH_LEN_W'($urandom_range(0, 31));
                        end
                    end
                    cnt = $urandom_range(0, 15);
                    wk  = $urandom_range(0, 31);
                end
            endcase
            write_setting(CFG_MONTH_LENGTHS, tbl);
            write_setting(CFG_MONTH_COUNT, CFG_DATA_W'(cnt));
            write_setting(CFG_WEEK_LENGTH, CFG_DATA_W'(wk));
            no_idle = (ph == STEADY_PHASE);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                run_advance(random_advance(ph == HEAVY_PHASE), 1'b0, '0);
            end
        end

        in_ch.valid <= 1'b0;
        no_idle = 1'b0;
        while (pending_stamps.size() != 0)
        begin
            @(posedge clk);
        end
        // quiet tail: anything arriving now is unexpected
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ===== custom_calendar_clock_advance.f =====
sv/ccca_pkg.sv
sv/ccca_if.sv
sv/ccca_cmpsub.sv
sv/custom_calendar_clock_advance.sv
tb/tb_custom_calendar_clock_advance.sv
